[hw/rtl/hds_pkg.sv]
// ----------------------------------------------------------------------------
// hds_pkg
// Shared constants, tables and word types of the heading displacement pipeline.
// ----------------------------------------------------------------------------
package hds_pkg;

	// rotation iterations, one pipeline stage each
	localparam int CORDIC_STAGES = 18;
	localparam int ATAN_ENTRIES  = 32;
	localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

	// heading units: 1/64 degree
	localparam logic [15:0] QUARTER_UNITS = 16'd5760;   // 90 degrees
	localparam logic [15:0] HALF_UNITS    = 16'd11520;  // 180 degrees
	localparam logic [15:0] TQ_UNITS      = 16'd17280;  // 270 degrees
	localparam logic [15:0] FULL_UNITS    = 16'd23040;  // 360 degrees

	// remainder inside a quadrant and its split r = 45*a + b
	localparam int RW          = 13;
	localparam int QW          = 7;
	localparam int BW          = 6;
	localparam int DIV45       = 45;
	localparam int PRE_SHIFT   = 9;    // 23040 = 45 << 9
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP_W     = 14;
	localparam logic [RECIP_W-1:0] RECIP_45 = RECIP_W'(((1 << RECIP_SHIFT) + DIV45 - 1) / DIV45);
	localparam int PROD_W      = RW + RECIP_W;

	// angle is 2^-32 turn; per-b fraction table holds floor((b*2^23 + 22) / 45)
	localparam int FRAC_W    = 32 - PRE_SHIFT;
	localparam int ZTAB_N    = DIV45;

	localparam logic [FRAC_W-1:0] ZTAB [ZTAB_N] = '{
		23'd0,       23'd186414,  23'd372827,  23'd559241,  23'd745654,  23'd932068,
		23'd1118481, 23'd1304895, 23'd1491308, 23'd1677722, 23'd1864135, 23'd2050549,
		23'd2236962, 23'd2423376, 23'd2609789, 23'd2796203, 23'd2982616, 23'd3169030,
		23'd3355443, 23'd3541857, 23'd3728270, 23'd3914684, 23'd4101097, 23'd4287511,
		23'd4473924, 23'd4660338, 23'd4846751, 23'd5033165, 23'd5219578, 23'd5405992,
		23'd5592405, 23'd5778819, 23'd5965232, 23'd6151646, 23'd6338059, 23'd6524473,
		23'd6710886, 23'd6897300, 23'd7083713, 23'd7270127, 23'd7456540, 23'd7642954,
		23'd7829367, 23'd8015781, 23'd8202194
	};

	// datapath widths
	localparam int ZW = 34;
	localparam int XW = 34;
	localparam int MW = 32;
	localparam int PW = 64;
	localparam int DW = PW - 30;
	localparam int SW = 36;

	localparam logic signed [XW-1:0] GAIN_INV = 34'sd652032874;
	localparam logic [PW-1:0]        ROUND_HALF = PW'(1) << 29;

	localparam logic [ZW-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		34'h20000000, 34'h12E4051E, 34'h09FB385B, 34'h051111D4, 34'h028B0D43, 34'h0145D7E1,
		34'h00A2F61E, 34'h00517C55, 34'h0028BE53, 34'h00145F2F, 34'h000A2F98, 34'h000517CC,
		34'h00028BE6, 34'h000145F3, 34'h0000A2FA, 34'h0000517D, 34'h000028BE, 34'h0000145F,
		34'h00000A30, 34'h00000518, 34'h0000028C, 34'h00000146, 34'h000000A3, 34'h00000051,
		34'h00000029, 34'h00000014, 34'h0000000A, 34'h00000005, 34'h00000003, 34'h00000001,
		34'h00000001, 34'h00000000
	};

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] POS_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        step_length;
	} carry_t;

	typedef struct packed {
		logic   move;
		quad_t  quad;
		carry_t carry;
	} side_t;

	typedef struct packed {
		side_t         side;
		logic [ZW-1:0] z;
	} ang_t;

	typedef struct packed {
		side_t                side;
		logic signed [XW-1:0] cx;
		logic signed [XW-1:0] cy;
	} rot_t;

endpackage

[hw/rtl/hds_angle.sv]
// ----------------------------------------------------------------------------
// hds_angle
// Splits the heading into quadrant and remainder and forms the start angle.
// ----------------------------------------------------------------------------
module hds_angle (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              up_ready,
	input  logic [15:0]       heading,
	input  hds_pkg::carry_t   carry,
	output logic              out_valid,
	input  logic              dn_ready,
	output hds_pkg::ang_t     out_word
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic                     move_c;
	hds_pkg::quad_t           quad_c;
	logic [hds_pkg::RW-1:0]   r_c;

	hds_pkg::side_t           side_s1, side_s2;
	logic [hds_pkg::RW-1:0]   r_s1, r_s2;
	logic [hds_pkg::QW-1:0]   a_s2;
	logic [hds_pkg::PROD_W-1:0] prod_c;
	logic [hds_pkg::RW-1:0]   b_full_c;
	logic [hds_pkg::BW-1:0]   b_c;
	hds_pkg::ang_t            out_s3;

	assign rdy3     = !v_s3 | dn_ready;
	assign rdy2     = !v_s2 | rdy3;
	assign rdy1     = !v_s1 | rdy2;
	assign up_ready = rdy1;

	always_comb begin
		move_c = heading < hds_pkg::FULL_UNITS;
		if (heading < hds_pkg::QUARTER_UNITS) begin
			quad_c = hds_pkg::QUAD_0;
			r_c    = hds_pkg::RW'(heading);
		end else if (heading < hds_pkg::HALF_UNITS) begin
			quad_c = hds_pkg::QUAD_1;
			r_c    = hds_pkg::RW'(heading - hds_pkg::QUARTER_UNITS);
		end else if (heading < hds_pkg::TQ_UNITS) begin
			quad_c = hds_pkg::QUAD_2;
			r_c    = hds_pkg::RW'(heading - hds_pkg::HALF_UNITS);
		end else begin
			quad_c = hds_pkg::QUAD_3;
			r_c    = hds_pkg::RW'(heading - hds_pkg::TQ_UNITS);
		end
	end

	// a = r / 45 by reciprocal, exact for every remainder below 5760
	assign prod_c   = hds_pkg::PROD_W'(r_s1) * hds_pkg::PROD_W'(hds_pkg::RECIP_45);
	assign b_full_c = r_s2 - hds_pkg::RW'(a_s2) * hds_pkg::RW'(hds_pkg::DIV45);
	assign b_c      = b_full_c[hds_pkg::BW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1.move  <= move_c;
			side_s1.quad  <= quad_c;
			side_s1.carry <= carry;
			r_s1          <= r_c;
		end
		if (rdy2) begin
			side_s2 <= side_s1;
			r_s2    <= r_s1;
			a_s2    <= prod_c[hds_pkg::RECIP_SHIFT +: hds_pkg::QW];
		end
		if (rdy3) begin
			out_s3.side <= side_s2;
			out_s3.z    <= {{(hds_pkg::ZW - hds_pkg::QW - hds_pkg::FRAC_W){1'b0}},
				a_s2, hds_pkg::ZTAB[b_c]};
		end
	end

	assign out_valid = v_s3;
	assign out_word  = out_s3;

endmodule

[hw/rtl/hds_cordic.sv]
// ----------------------------------------------------------------------------
// hds_cordic
// Rotation-mode CORDIC, one iteration per pipeline stage.
// ----------------------------------------------------------------------------
module hds_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            up_ready,
	input  hds_pkg::ang_t   in_word,
	output logic            out_valid,
	input  logic            dn_ready,
	output hds_pkg::rot_t   out_word
);

	localparam int N = hds_pkg::CORDIC_ITERS;

	logic [N-1:0]                  v_s;
	logic [N-1:0]                  rdy;
	logic signed [hds_pkg::XW-1:0] x_s [N];
	logic signed [hds_pkg::XW-1:0] y_s [N];
	logic signed [hds_pkg::ZW-1:0] z_s [N];
	hds_pkg::side_t                side_s [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic                          vi;
		logic signed [hds_pkg::XW-1:0] xi, yi;
		logic signed [hds_pkg::ZW-1:0] zi;
		hds_pkg::side_t                si;
		logic                          dir;

		if (i == 0) begin : g_first
			assign vi = in_valid;
			assign xi = hds_pkg::GAIN_INV;
			assign yi = '0;
			assign zi = $signed(in_word.z);
			assign si = in_word.side;
		end else begin : g_next
			assign vi = v_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign si = side_s[i-1];
		end

		if (i == N - 1) begin : g_last
			assign rdy[i] = !v_s[i] | dn_ready;
		end else begin : g_mid
			assign rdy[i] = !v_s[i] | rdy[i+1];
		end

		// rotate toward zero residual angle
		assign dir = !zi[hds_pkg::ZW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i]) begin
				side_s[i] <= si;
				if (dir) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - $signed(hds_pkg::ATAN_TAB[i]);
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + $signed(hds_pkg::ATAN_TAB[i]);
				end
			end
		end
	end

	assign up_ready      = rdy[0];
	assign out_valid     = v_s[N-1];
	assign out_word.side = side_s[N-1];
	assign out_word.cx   = x_s[N-1];
	assign out_word.cy   = y_s[N-1];

endmodule

[hw/rtl/hds_scale.sv]
// ----------------------------------------------------------------------------
// hds_scale
// Maps quadrant, scales by distance, rounds, adds to the point and clamps.
// ----------------------------------------------------------------------------
module hds_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               up_ready,
	input  hds_pkg::rot_t      in_word,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic               saturated
);

	logic v_s1, v_s2, v_s3, res_valid_q;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [hds_pkg::XW-1:0] ax_c, ay_c;
	logic                   nxn_c, nyn_c;
	logic [hds_pkg::MW-1:0] smag_c, cmag_c;
	logic                   sneg_c, cneg_c;

	hds_pkg::side_t         side_s1, side_s2, side_s3;
	logic [hds_pkg::MW-1:0] smag_s1, cmag_s1;
	logic                   sneg_s1, cneg_s1, sneg_s2, cneg_s2, sneg_s3, cneg_s3;
	logic [hds_pkg::PW-1:0] sprod_s2, cprod_s2;
	logic [hds_pkg::PW-1:0] sround_c, cround_c;
	logic [hds_pkg::DW-1:0] ds_s3, dc_s3;

	logic signed [hds_pkg::SW-1:0] px_c, py_c, ds_c, dc_c, sx_c, sy_c;
	logic [32:0]                   cx_c, cy_c;

	logic signed [31:0] new_x_q, new_y_q;
	logic               sat_q;

	assign rdy4     = !res_valid_q | !result_stall;
	assign rdy3     = !v_s3 | rdy4;
	assign rdy2     = !v_s2 | rdy3;
	assign rdy1     = !v_s1 | rdy2;
	assign up_ready = rdy1;

	function automatic logic [32:0] clamp_word(input logic signed [hds_pkg::SW-1:0] v);
		logic [32:0] r;
		if (v > $signed(hds_pkg::SW'(hds_pkg::POS_MAX))) begin
			r = {1'b1, hds_pkg::POS_MAX};
		end else if (v < -$signed(hds_pkg::SW'(hds_pkg::POS_MIN))) begin
			r = {1'b1, hds_pkg::POS_MIN};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	// magnitudes and signs, then the quadrant picks and flips them
	always_comb begin
		nxn_c = in_word.cx[hds_pkg::XW-1];
		nyn_c = in_word.cy[hds_pkg::XW-1];
		ax_c  = nxn_c ? hds_pkg::XW'(-in_word.cx) : hds_pkg::XW'(in_word.cx);
		ay_c  = nyn_c ? hds_pkg::XW'(-in_word.cy) : hds_pkg::XW'(in_word.cy);
		unique case (in_word.side.quad)
			hds_pkg::QUAD_0: begin
				smag_c = ay_c[hds_pkg::MW-1:0]; sneg_c = nyn_c;
				cmag_c = ax_c[hds_pkg::MW-1:0]; cneg_c = nxn_c;
			end
			hds_pkg::QUAD_1: begin
				smag_c = ax_c[hds_pkg::MW-1:0]; sneg_c = nxn_c;
				cmag_c = ay_c[hds_pkg::MW-1:0]; cneg_c = !nyn_c;
			end
			hds_pkg::QUAD_2: begin
				smag_c = ay_c[hds_pkg::MW-1:0]; sneg_c = !nyn_c;
				cmag_c = ax_c[hds_pkg::MW-1:0]; cneg_c = !nxn_c;
			end
			hds_pkg::QUAD_3: begin
				smag_c = ax_c[hds_pkg::MW-1:0]; sneg_c = !nxn_c;
				cmag_c = ay_c[hds_pkg::MW-1:0]; cneg_c = nyn_c;
			end
			default: begin
				smag_c = '0; sneg_c = 1'b0;
				cmag_c = '0; cneg_c = 1'b0;
			end
		endcase
	end

	assign sround_c = sprod_s2 + hds_pkg::ROUND_HALF;
	assign cround_c = cprod_s2 + hds_pkg::ROUND_HALF;

	// x moves against the sine, y along the cosine
	always_comb begin
		px_c = hds_pkg::SW'(side_s3.carry.pos_x);
		py_c = hds_pkg::SW'(side_s3.carry.pos_y);
		ds_c = $signed(hds_pkg::SW'(ds_s3));
		dc_c = $signed(hds_pkg::SW'(dc_s3));
		sx_c = sneg_s3 ? px_c + ds_c : px_c - ds_c;
		sy_c = cneg_s3 ? py_c - dc_c : py_c + dc_c;
		cx_c = clamp_word(sx_c);
		cy_c = clamp_word(sy_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) res_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1 <= in_word.side;
			smag_s1 <= smag_c;
			cmag_s1 <= cmag_c;
			sneg_s1 <= sneg_c;
			cneg_s1 <= cneg_c;
		end
		if (rdy2) begin
			side_s2  <= side_s1;
			sneg_s2  <= sneg_s1;
			cneg_s2  <= cneg_s1;
			sprod_s2 <= hds_pkg::PW'(side_s1.carry.step_length) * hds_pkg::PW'(smag_s1);
			cprod_s2 <= hds_pkg::PW'(side_s1.carry.step_length) * hds_pkg::PW'(cmag_s1);
		end
		if (rdy3) begin
			side_s3 <= side_s2;
			sneg_s3 <= sneg_s2;
			cneg_s3 <= cneg_s2;
			ds_s3   <= sround_c[hds_pkg::PW-1:30];
			dc_s3   <= cround_c[hds_pkg::PW-1:30];
		end
		if (rdy4) begin
			if (side_s3.move) begin
				new_x_q <= $signed(cx_c[31:0]);
				new_y_q <= $signed(cy_c[31:0]);
				sat_q   <= cx_c[32] | cy_c[32];
			end else begin
				new_x_q <= side_s3.carry.pos_x;
				new_y_q <= side_s3.carry.pos_y;
				sat_q   <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign new_x        = new_x_q;
	assign new_y        = new_y_q;
	assign saturated    = sat_q;

endmodule

[hw/rtl/heading_displacement_step.sv]
// ----------------------------------------------------------------------------
// heading_displacement_step
// Moves a Q16.16 point a given distance along a heading (pipelined CORDIC).
// ----------------------------------------------------------------------------
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   --------------------------
//  item      pos_x, pos_y, heading, step_length         item_valid / item_stall
//  result    new_x, new_y, saturated                    result_valid / result_stall
//
//  one word per cycle while result_stall is low; angle, CORDIC, then scale stages
//  the depth is set by the CORDIC, one rotation iteration per register stage
//  reset clears only the valid bits; no clearing pass, no kept state
//  each stage advances when it is empty or the next one moves, so bubbles
//  collapse and words keep entering while a finished result waits
// ----------------------------------------------------------------------------
module heading_displacement_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [15:0]        heading,
	input  logic [31:0]        step_length,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic               saturated
);

	hds_pkg::carry_t carry;
	hds_pkg::ang_t   ang_word;
	hds_pkg::rot_t   rot_word;
	logic            ang_valid, ang_ready, rot_valid, rot_ready, scl_ready;

	assign carry.pos_x       = pos_x;
	assign carry.pos_y       = pos_y;
	assign carry.step_length = step_length;

	hds_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.up_ready  (ang_ready),
		.heading   (heading),
		.carry     (carry),
		.out_valid (ang_valid),
		.dn_ready  (rot_ready),
		.out_word  (ang_word)
	);

	hds_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ang_valid),
		.up_ready  (rot_ready),
		.in_word   (ang_word),
		.out_valid (rot_valid),
		.dn_ready  (scl_ready),
		.out_word  (rot_word)
	);

	hds_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (rot_valid),
		.up_ready     (scl_ready),
		.in_word      (rot_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.new_x        (new_x),
		.new_y        (new_y),
		.saturated    (saturated)
	);

	assign item_stall = !ang_ready;

	// an empty output register frees every stage behind it
	a_empty_no_stall : assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled while output register empty");

	// a clamped word carries a limit value in at least one coordinate
	a_sat_at_limit : assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && saturated) |->
			(new_x == $signed(hds_pkg::POS_MAX) || new_x == $signed(hds_pkg::POS_MIN) ||
			 new_y == $signed(hds_pkg::POS_MAX) || new_y == $signed(hds_pkg::POS_MIN)))
		else $error("saturated word without a clamped coordinate");

	// a stalled result word holds until taken
	a_stall_holds_word : assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(new_x) && $stable(new_y) && $stable(saturated)))
		else $error("stalled result word changed");

endmodule
